### rtl/nmea_rmc_position_parser_assert.svh
// Assertion macros for the checker file.
`ifndef NMEA_RMC_POSITION_PARSER_ASSERT_SVH
`define NMEA_RMC_POSITION_PARSER_ASSERT_SVH

// Clocked check, switched off while reset is held.
`define NRP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define NRP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/nrp_pkg.sv
package nrp_pkg;

	localparam int FRACTION_DIGITS = 5;
	localparam int POW_W = $clog2(10 ** FRACTION_DIGITS + 1);

	localparam logic [2:0] HEADER_LEN = 3'd7;

	localparam logic [30:0] LAT_MAX = 31'd900000000;
	localparam logic [30:0] LON_MAX = 31'd1800000000;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_C      = 8'h43;
	localparam logic [7:0] CH_E      = 8'h45;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_M      = 8'h4D;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_R      = 8'h52;

	localparam logic [2:0] FLD_TIME   = 3'd0;
	localparam logic [2:0] FLD_STATUS = 3'd1;
	localparam logic [2:0] FLD_LAT    = 3'd2;
	localparam logic [2:0] FLD_NS     = 3'd3;
	localparam logic [2:0] FLD_LON    = 3'd4;
	localparam logic [2:0] FLD_EW     = 3'd5;

	typedef struct packed {
		logic       seen_point;
		logic [2:0] frac_count;
	} num_state_t;

	typedef struct packed {
		logic        fix_valid;
		logic [30:0] latitude;
		logic [31:0] longitude;
	} fix_t;

	function automatic logic [7:0] hdr_char(input logic [2:0] idx);
		logic [7:0] c;
		case (idx)
			3'd0: c = CH_DOLLAR;
			3'd1: c = CH_G;
			3'd2: c = CH_P;
			3'd3: c = CH_R;
			3'd4: c = CH_M;
			3'd5: c = CH_C;
			3'd6: c = CH_COMMA;
			default: c = CH_DOLLAR;
		endcase
		return c;
	endfunction

	function automatic logic [POW_W-1:0] pow10(input logic [2:0] n);
		logic [POW_W-1:0] r;
		r = POW_W'(1);
		for (int i = 0; i < FRACTION_DIGITS; i++) begin
			if (3'(i) < n) begin
				r = POW_W'(r * 10);
			end
		end
		return r;
	endfunction

endpackage

### rtl/nrp_num_acc.sv
module nrp_num_acc
	import nrp_pkg::*;
(
	input  logic [30:0] acc,
	input  logic [30:0] limit,
	input  logic [7:0]  rx_byte,
	input  num_state_t  num_st,
	output num_state_t  num_next,
	output logic [30:0] char_acc,
	output logic [30:0] pad_acc
);

	logic              is_digit;
	logic [34:0]       push;
	logic [30:0]       push_acc;
	logic [2:0]        pad_n;
	logic [POW_W-1:0]  scale;
	logic [POW_W+30:0] prod;

	always_comb begin
		is_digit = rx_byte inside {[CH_ZERO:CH_NINE]};
		push = {4'b0, acc} * 35'd10 + {31'b0, rx_byte[3:0]};
		push_acc = (push > {4'b0, limit}) ? limit : push[30:0];

		num_next = num_st;
		char_acc = acc;
		if (rx_byte == CH_POINT) begin
			num_next.seen_point = 1'b1;
		end else if (is_digit) begin
			if (!num_st.seen_point) begin
				char_acc = push_acc;
			end else if (num_st.frac_count < 3'(FRACTION_DIGITS)) begin
				char_acc = push_acc;
				num_next.frac_count = num_st.frac_count + 3'd1;
			end
		end

		// missing fraction digits: one scale by a power of ten, saturating
		pad_n = 3'(FRACTION_DIGITS) - num_st.frac_count;
		scale = pow10(pad_n);
		prod = {{POW_W{1'b0}}, acc} * {31'b0, scale};
		pad_acc = (prod > {{POW_W{1'b0}}, limit}) ? limit : prod[30:0];
	end

endmodule

### rtl/nrp_parser.sv
module nrp_parser
	import nrp_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic [7:0] rx_byte,
	output logic       emit,
	output fix_t       fix
);

	logic [2:0]  hdr_q, hdr_n;
	logic [2:0]  field_q, field_n;
	logic        status_q, status_n;
	logic [29:0] lat_q, lat_n;
	logic [30:0] lon_q, lon_n;
	num_state_t  num_q, num_n;
	logic        north_q, north_n;
	logic        east_q, east_n;

	logic        body;
	logic        is_comma;
	logic [30:0] acc_sel;
	logic [30:0] limit_sel;
	num_state_t  num_char;
	logic [30:0] char_acc;
	logic [30:0] pad_acc;

	assign acc_sel   = (field_q == FLD_LON) ? lon_q : {1'b0, lat_q};
	assign limit_sel = (field_q == FLD_LON) ? LON_MAX : LAT_MAX;

	nrp_num_acc u_num_acc (
		.acc      (acc_sel),
		.limit    (limit_sel),
		.rx_byte  (rx_byte),
		.num_st   (num_q),
		.num_next (num_char),
		.char_acc (char_acc),
		.pad_acc  (pad_acc)
	);

	always_comb begin
		body     = (hdr_q == HEADER_LEN);
		is_comma = (rx_byte == CH_COMMA);
		emit     = body && is_comma && (field_q >= FLD_EW);

		fix.fix_valid = status_q;
		fix.latitude  = north_q ? {1'b0, lat_q} : 31'd0 - {1'b0, lat_q};
		fix.longitude = east_q ? {1'b0, lon_q} : 32'd0 - {1'b0, lon_q};

		hdr_n    = hdr_q;
		field_n  = field_q;
		status_n = status_q;
		lat_n    = lat_q;
		lon_n    = lon_q;
		num_n    = num_q;
		north_n  = north_q;
		east_n   = east_q;

		if (rx_byte == CH_DOLLAR) begin
			hdr_n = 3'd1;
		end else if (!body) begin
			hdr_n = (rx_byte == hdr_char(hdr_q)) ? hdr_q + 3'd1 : 3'd0;
		end else if (is_comma) begin
			field_n = field_q + 3'd1;
			case (field_q)
				FLD_TIME: begin
					status_n = 1'b0;
				end
				FLD_STATUS: begin
					lat_n = '0;
					num_n = '0;
				end
				FLD_LAT: begin
					lat_n   = pad_acc[29:0];
					num_n   = '0;
					north_n = 1'b0;
				end
				FLD_NS: begin
					lon_n = '0;
					num_n = '0;
				end
				FLD_LON: begin
					lon_n  = pad_acc;
					num_n  = '0;
					east_n = 1'b0;
				end
				default: begin
					hdr_n = 3'd0;
				end
			endcase
		end else begin
			case (field_q)
				FLD_STATUS: status_n = (rx_byte == CH_A);
				FLD_LAT: begin
					lat_n = char_acc[29:0];
					num_n = num_char;
				end
				FLD_NS:  north_n = (rx_byte == CH_N);
				FLD_LON: begin
					lon_n = char_acc;
					num_n = num_char;
				end
				FLD_EW:  east_n = (rx_byte == CH_E);
				default: ;
			endcase
		end

		// new sentence or sentence done: drop everything in the body
		if ((rx_byte == CH_DOLLAR) || (!body && hdr_n == HEADER_LEN) || emit) begin
			field_n  = FLD_TIME;
			status_n = 1'b0;
			lat_n    = '0;
			lon_n    = '0;
			num_n    = '0;
			north_n  = 1'b0;
			east_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_q    <= '0;
			field_q  <= FLD_TIME;
			status_q <= 1'b0;
			lat_q    <= '0;
			lon_q    <= '0;
			num_q    <= '0;
			north_q  <= 1'b0;
			east_q   <= 1'b0;
		end else if (en) begin
			hdr_q    <= hdr_n;
			field_q  <= field_n;
			status_q <= status_n;
			lat_q    <= lat_n;
			lon_q    <= lon_n;
			num_q    <= num_n;
			north_q  <= north_n;
			east_q   <= east_n;
		end
	end

endmodule

### rtl/nrp_out_reg.sv
module nrp_out_reg
	import nrp_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  fix_t in_fix,
	output logic free,
	input  logic m_tready,
	output logic m_tvalid,
	output fix_t out_fix
);

	logic valid_q;
	fix_t fix_q;

	assign free     = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign out_fix  = fix_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && free) begin
			fix_q <= in_fix;
		end
	end

endmodule

### rtl/nmea_rmc_position_parser.sv
// NMEA 0183 RMC position parser. Takes one received character per transaction and emits one
// fix per "$GPRMC," sentence when the comma after the E/W field arrives. Throughput is one
// character per clock unless stalled as below: a character waits in the input register while
// the parser updates its state, and a fix enters the output register as the parser takes its
// closing comma. The input side stalls only when a fix is due and the output register still
// holds an untaken one. Latitude and longitude are signed, in units of 1e-5 minute, saturating
// at 90 and 180 degrees. No clearing pass after reset.
module nmea_rmc_position_parser
	import nrp_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [30:0] latitude, [62:31] longitude, [63] zero
	output logic        m_tuser    // [0] fix_valid
);

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       emit;
	logic       free;
	logic       advance;
	fix_t       fix;
	fix_t       out_fix;

	assign advance  = valid_s1 && (!emit || free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1 <= s_tdata;
		end
	end

	nrp_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (advance),
		.rx_byte (byte_s1),
		.emit    (emit),
		.fix     (fix)
	);

	nrp_out_reg u_out_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (advance && emit),
		.in_fix   (fix),
		.free     (free),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.out_fix  (out_fix)
	);

	assign m_tdata = {1'b0, out_fix.longitude, out_fix.latitude};
	assign m_tuser = out_fix.fix_valid;

endmodule

### rtl/nrp_checker.sv
`include "nmea_rmc_position_parser_assert.svh"

module nrp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic        m_tuser
);

	`NRP_ASSERT(a_out_hold, (m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)), "stalled fix changed")
	`NRP_ASSERT(a_in_stall, (!s_tready |-> m_tvalid && !m_tready), "input stalled with output free")
	`NRP_ASSERT(a_lat_range, (m_tvalid |-> ($signed(m_tdata[30:0]) <= 31'sd900000000) && ($signed(m_tdata[30:0]) >= -31'sd900000000)), "latitude out of range")
	`NRP_ASSERT(a_lon_range, (m_tvalid |-> ($signed(m_tdata[62:31]) <= 32'sd1800000000) && ($signed(m_tdata[62:31]) >= -32'sd1800000000) && !m_tdata[63]), "longitude out of range")

endmodule

bind nmea_rmc_position_parser nrp_checker u_nrp_checker (.*);
